@@ rtl/hsh_pkg.sv @@
// Package for the HalfSipHash-2-4 engine: sequencer states, register
// indexes, lane initialization constants and the shared ARX round function.
// No dependencies.
`timescale 1ns / 1ps

package hsh_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_TAIL,
    ST_FINAL,
    ST_EMIT
  } hsh_state_t;

  // Four 32-bit lanes v0..v3
  typedef logic [3:0][31:0] hsh_lanes_t;

  // Configuration register indexes
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // Lane initialization constants and finalization marker
  localparam logic [31:0] LANE_INIT_2 = 32'h6c796765;
  localparam logic [31:0] LANE_INIT_3 = 32'h74656462;
  localparam logic [31:0] FINAL_MARK  = 32'h000000ff;

  // One ARX round over all four lanes
  function automatic hsh_lanes_t arx_round(input hsh_lanes_t v);
    logic [31:0] a, b, c, d;
    hsh_lanes_t r;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; b = {b[26:0], b[31:27]}; b = b ^ a; a = {a[15:0], a[31:16]};
    c = c + d; d = {d[23:0], d[31:24]}; d = d ^ c;
    a = a + d; d = {d[24:0], d[31:25]}; d = d ^ a;
    c = c + b; b = {b[18:0], b[31:19]}; b = b ^ c; c = {c[15:0], c[31:16]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

@@ rtl/halfsiphash_2_4_engine.sv @@
// HalfSipHash-2-4 engine: one ARX round unit shared under a small sequencer.
// A non-last word is compressed in COMPRESS_ROUNDS rounds; a last word that is full
// is compressed likewise, then a length-only tail block takes COMPRESS_ROUNDS rounds and
// finalization FINAL_ROUNDS rounds, and the emit state lands its hash in the output register.
// The single round unit is shared, so in_stall holds off a new word until the last one is done.
// Reset (rst_n low, synchronous): keys zero, no open message, output empty.
`timescale 1ns / 1ps

module halfsiphash_2_4_engine
  import hsh_pkg::*;
#(
  parameter int COMPRESS_ROUNDS = 2,
  parameter int FINAL_ROUNDS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  localparam int MAX_ROUNDS = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS
                                                              : FINAL_ROUNDS;
  localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam logic [RW-1:0] COMP_LAST  = RW'(COMPRESS_ROUNDS - 1);
  localparam logic [RW-1:0] FINAL_LAST = RW'(FINAL_ROUNDS - 1);

  hsh_state_t  state_r, state_nxt;
  hsh_lanes_t  lane_r, lane_nxt;
  logic [31:0] msg_r, msg_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        open_r, open_nxt;
  logic        last_r, last_nxt;
  logic [31:0] key_lo_r, key_hi_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;

  logic        in_acc;
  logic        emit_go;
  logic        full_word;
  hsh_state_t  phase;
  hsh_lanes_t  rin, rout;
  logic [31:0] cur_msg;
  logic [RW-1:0] cur_rnd;
  logic        rnd_done;
  logic        cur_last;
  logic [31:0] tail_word;
  logic [31:0] byte_mask;
  logic [7:0]  len_base;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign emit_go        = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // A non-last word, or a last word with four or more bytes, is compressed whole
  assign full_word = !in_last_word || (in_byte_count >= 3'd4);
  assign byte_mask = ~(32'hffffffff << {in_byte_count[1:0], 3'b000});
  assign len_base  = open_r ? len_r : 8'd0;

  // Pick the phase worked on this cycle
  always_comb begin
    phase = state_r;
    if (state_r == ST_IDLE) begin
      phase = full_word ? ST_MSG : ST_TAIL;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full_word) begin
            state_nxt = (COMPRESS_ROUNDS == 1) ? (in_last_word ? ST_TAIL : ST_IDLE)
                                               : ST_MSG;
          end else begin
            state_nxt = (COMPRESS_ROUNDS == 1) ? ST_FINAL : ST_TAIL;
          end
        end
      end
      ST_MSG: begin
        if (rnd_done) state_nxt = last_r ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        if (rnd_done) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (rnd_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath: round input, shared ARX round, lane and counter updates
  always_comb begin
    rin       = lane_r;
    cur_msg   = msg_r;
    cur_rnd   = rnd_r;
    cur_last  = last_r;
    len_nxt   = len_r;
    open_nxt  = open_r;
    last_nxt  = last_r;
    tail_word = 32'd0;

    // Load lanes and fold the word in on acceptance
    if (state_r == ST_IDLE) begin
      cur_rnd  = '0;
      cur_last = in_last_word;
      if (open_r) begin
        rin = lane_r;
      end else begin
        rin[0] = key_lo_r;
        rin[1] = key_hi_r;
        rin[2] = key_lo_r ^ LANE_INIT_2;
        rin[3] = key_hi_r ^ LANE_INIT_3;
      end
      if (full_word) begin
        len_nxt = len_base + 8'd4;
        cur_msg = in_message_word;
      end else begin
        len_nxt = len_base + {6'd0, in_byte_count[1:0]};
        cur_msg = (in_message_word & byte_mask) | {len_nxt, 24'd0};
      end
      rin[3] = rin[3] ^ cur_msg;
      if (in_acc) begin
        open_nxt = 1'b1;
        last_nxt = in_last_word;
      end else begin
        len_nxt = len_r;
      end
    end

    rnd_done = (phase == ST_FINAL) ? (cur_rnd == FINAL_LAST) : (cur_rnd == COMP_LAST);
    rout     = arx_round(rin);
    lane_nxt = lane_r;
    msg_nxt  = cur_msg;
    rnd_nxt  = rnd_r;

    if ((state_r == ST_IDLE && in_acc) || state_r == ST_MSG || state_r == ST_TAIL ||
        state_r == ST_FINAL) begin
      lane_nxt = rout;
      rnd_nxt  = rnd_done ? '0 : cur_rnd + 1'b1;
      if (rnd_done && phase != ST_FINAL) begin
        lane_nxt[0] = rout[0] ^ cur_msg;
        if (phase == ST_MSG && cur_last) begin
          // Start the length-only tail block
          tail_word   = {len_nxt, 24'd0};
          msg_nxt     = tail_word;
          lane_nxt[3] = rout[3] ^ tail_word;
        end else if (phase == ST_TAIL) begin
          lane_nxt[2] = rout[2] ^ FINAL_MARK;
        end
      end
    end

    // Close the message when its hash is emitted
    if (emit_go) open_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      len_r       <= 8'd0;
      open_r      <= 1'b0;
      last_r      <= 1'b0;
      key_lo_r    <= 32'd0;
      key_hi_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      len_r   <= len_nxt;
      open_r  <= open_nxt;
      last_r  <= last_nxt;
      if (cfg_we && cfg_index == REG_KEY_LOW)  key_lo_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_KEY_HIGH) key_hi_r <= cfg_wdata;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    msg_r  <= msg_nxt;
    if (emit_go) out_hash_r <= lane_r[1] ^ lane_r[3];
  end

  // Checks
  a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> open_r)
    else $error("message closed before its hash was emitted");

  a_rnd_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINAL |-> (int'(rnd_r) < FINAL_ROUNDS))
    else $error("finalization round count overran");

  a_rnd_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSG || state_r == ST_TAIL) |-> (int'(rnd_r) < COMPRESS_ROUNDS))
    else $error("compression round count overran");

  a_open_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_word) |=> open_r)
    else $error("message not open after a non-last word");

endmodule
